// File: rtl/ifbpc_pkg.sv
// shared constants and types for the ipv4 flow byte and packet counter
// no dependencies

package ifbpc_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   localparam logic [2:0] ST_NOT_COUNTED = 3'd0;
   localparam logic [2:0] ST_HIT         = 3'd1;
   localparam logic [2:0] ST_NEW         = 3'd2;
   localparam logic [2:0] ST_FULL        = 3'd3;
   localparam logic [2:0] ST_READ_VALID  = 3'd4;
   localparam logic [2:0] ST_READ_EMPTY  = 3'd5;

   localparam logic OP_FRAME = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;
   localparam logic [15:0] MIN_FRAME_LEN  = 16'd34;
   localparam logic [3:0]  MIN_IHL        = 4'd5;

   typedef struct packed {
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  proto;
   } flow_key_type;

   typedef struct packed {
      flow_key_type key;
      logic [63:0]  byte_total;
      logic [63:0]  packet_total;
   } flow_entry_type;

   localparam int ENTRY_W = $bits(flow_entry_type);

endpackage

// File: rtl/ifbpc_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module ifbpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ipv4_flow_byte_packet_counter.sv
// top level: frame parser and five-tuple flow table with byte and packet totals
// depends on ifbpc_pkg and ifbpc_ram

// One word per cycle is taken while the block is idle and no waiting result is
// held by rsp_stall. Frame bytes other than the last are parsed in the idle state.
// On the last byte of a counted frame the key is searched in the flow table
// memory, each entry read (S_RD) and then compared (S_CMP), over the entries in use
// only; the entry is written back in the final compare state, or in S_RD when the
// table is empty. A table read waits for the registered ram output in S_RDOUT.
// Entries are claimed in order and never freed, so an entry count stands in for
// valid bits and no clearing pass follows reset.

module ipv4_flow_byte_packet_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic [7:0]  req_read_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_entry_index,
   output logic [31:0] rsp_src_addr,
   output logic [31:0] rsp_dst_addr,
   output logic [15:0] rsp_src_port,
   output logic [15:0] rsp_dst_port,
   output logic [7:0]  rsp_proto,
   output logic [63:0] rsp_byte_total,
   output logic [63:0] rsp_packet_total
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RD,
      S_CMP,
      S_RDOUT
   } state_type;

   state_type                       state_ff, state_in;
   logic [ifbpc_pkg::CNT_W-1:0]     count_ff, count_in;
   logic [ifbpc_pkg::IDX_W-1:0]     scan_ff, scan_in;
   ifbpc_pkg::flow_key_type         key_ff, key_in;
   logic [15:0]                     len_ff, len_in;

   logic [15:0]                     pos_ff, pos_in;
   logic [15:0]                     ether_ff, ether_in;
   logic [3:0]                      hw_ff, hw_in;
   ifbpc_pkg::flow_key_type         pkey_ff, pkey_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [2:0]                      status_ff, status_in;
   logic [7:0]                      index_ff, index_in;
   ifbpc_pkg::flow_key_type         okey_ff, okey_in;
   logic [63:0]                     obytes_ff, obytes_in;
   logic [63:0]                     opkts_ff, opkts_in;

   logic                            wr_en;
   logic [ifbpc_pkg::IDX_W-1:0]     wr_addr;
   ifbpc_pkg::flow_entry_type       wr_entry;
   logic [ifbpc_pkg::IDX_W-1:0]     rd_addr;
   logic [ifbpc_pkg::ENTRY_W-1:0]   rd_raw;
   ifbpc_pkg::flow_entry_type       rd_entry;

   logic                            accept;
   logic [6:0]                      tp;
   logic [6:0]                      tp_fin;
   logic [15:0]                     len_now;
   ifbpc_pkg::flow_key_type         fin_key;
   logic                            counted;
   logic                            keep_ports;
   logic                            rd_ok;

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rd_entry  = ifbpc_pkg::flow_entry_type'(rd_raw);
   assign rd_ok     = 32'(req_read_index) < 32'(count_ff);
   assign tp        = 7'd14 + {1'b0, hw_ff, 2'b00};
   assign tp_fin    = 7'd14 + {1'b0, hw_in, 2'b00};
   assign len_now   = (pos_ff != 16'hFFFF) ? pos_ff + 16'd1 : 16'hFFFF;

   ifbpc_ram #(
      .WIDTH (ifbpc_pkg::ENTRY_W),
      .DEPTH (ifbpc_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // byte parse of the current word
   always_comb begin
      ether_in = ether_ff;
      hw_in    = hw_ff;
      pkey_in  = pkey_ff;
      if (pos_ff == 16'd12) begin
         ether_in[15:8] = req_data_byte;
      end else if (pos_ff == 16'd13) begin
         ether_in[7:0] = req_data_byte;
      end else if (pos_ff == 16'd14) begin
         hw_in = req_data_byte[3:0];
      end else if (pos_ff == 16'd23) begin
         pkey_in.proto = req_data_byte;
      end else if (pos_ff >= 16'd26 && pos_ff <= 16'd29) begin
         pkey_in.src_addr = {pkey_ff.src_addr[23:0], req_data_byte};
      end else if (pos_ff >= 16'd30 && pos_ff <= 16'd33) begin
         pkey_in.dst_addr = {pkey_ff.dst_addr[23:0], req_data_byte};
      end
      if (pos_ff > 16'd14 && hw_ff >= ifbpc_pkg::MIN_IHL) begin
         if (pos_ff == 16'(tp) || pos_ff == 16'(tp) + 16'd1) begin
            pkey_in.sport = {pkey_ff.sport[7:0], req_data_byte};
         end else if (pos_ff == 16'(tp) + 16'd2 || pos_ff == 16'(tp) + 16'd3) begin
            pkey_in.dport = {pkey_ff.dport[7:0], req_data_byte};
         end
      end
      counted = (ether_in == ifbpc_pkg::ETHERTYPE_IPV4) &&
                (len_now >= ifbpc_pkg::MIN_FRAME_LEN) && (hw_in >= ifbpc_pkg::MIN_IHL);
      keep_ports = (pkey_in.proto == ifbpc_pkg::PROTO_TCP &&
                    len_now >= 16'(tp_fin) + 16'd20) ||
                   (pkey_in.proto == ifbpc_pkg::PROTO_UDP &&
                    len_now >= 16'(tp_fin) + 16'd8);
      fin_key = pkey_in;
      if (!keep_ports) begin
         fin_key.sport = '0;
         fin_key.dport = '0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      index_in     = index_ff;
      okey_in      = okey_ff;
      obytes_in    = obytes_ff;
      opkts_in     = opkts_ff;
      wr_en        = 1'b0;
      wr_addr      = scan_ff;
      wr_entry     = '0;
      rd_addr      = scan_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_opcode == ifbpc_pkg::OP_READ) begin
               rd_addr = ifbpc_pkg::IDX_W'(req_read_index);
               if (rd_ok) begin
                  index_in = req_read_index;
                  state_in = S_RDOUT;
               end else begin
                  rsp_valid_in = 1'b1;
                  status_in    = ifbpc_pkg::ST_READ_EMPTY;
                  index_in     = req_read_index;
                  okey_in      = '0;
                  obytes_in    = '0;
                  opkts_in     = '0;
               end
            end else if (accept) begin
               pos_in = len_now;
               if (req_last_byte) begin
                  pos_in = '0;
                  if (!counted) begin
                     rsp_valid_in = 1'b1;
                     status_in    = ifbpc_pkg::ST_NOT_COUNTED;
                     index_in     = '0;
                     okey_in      = '0;
                     obytes_in    = '0;
                     opkts_in     = '0;
                  end else begin
                     key_in   = fin_key;
                     len_in   = len_now;
                     scan_in  = '0;
                     state_in = S_RD;
                  end
               end
            end
         end
         S_RD: begin
            if (count_ff == '0) begin
               state_in = S_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = ifbpc_pkg::ST_NEW;
               index_in     = '0;
               okey_in      = key_ff;
               obytes_in    = 64'(len_ff);
               opkts_in     = 64'd1;
               wr_en        = 1'b1;
               wr_addr      = '0;
               wr_entry     = '{key: key_ff, byte_total: 64'(len_ff), packet_total: 64'd1};
               count_in     = count_ff + 1'b1;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (rd_entry.key == key_ff) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = ifbpc_pkg::ST_HIT;
               index_in     = 8'(scan_ff);
               okey_in      = key_ff;
               obytes_in    = rd_entry.byte_total + 64'(len_ff);
               opkts_in     = rd_entry.packet_total + 64'd1;
               wr_en        = 1'b1;
               wr_addr      = scan_ff;
               wr_entry     = '{key: key_ff,
                                byte_total: rd_entry.byte_total + 64'(len_ff),
                                packet_total: rd_entry.packet_total + 64'd1};
            end else if (32'(scan_ff) + 32'd1 == 32'(count_ff)) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               okey_in      = key_ff;
               if (count_ff < ifbpc_pkg::CNT_W'(ifbpc_pkg::TABLE_DEPTH)) begin
                  status_in = ifbpc_pkg::ST_NEW;
                  index_in  = 8'(count_ff);
                  obytes_in = 64'(len_ff);
                  opkts_in  = 64'd1;
                  wr_en     = 1'b1;
                  wr_addr   = ifbpc_pkg::IDX_W'(count_ff);
                  wr_entry  = '{key: key_ff, byte_total: 64'(len_ff), packet_total: 64'd1};
                  count_in  = count_ff + 1'b1;
               end else begin
                  status_in = ifbpc_pkg::ST_FULL;
                  index_in  = '0;
                  obytes_in = '0;
                  opkts_in  = '0;
               end
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_RDOUT: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            status_in    = ifbpc_pkg::ST_READ_VALID;
            okey_in      = rd_entry.key;
            obytes_in    = rd_entry.byte_total;
            opkts_in     = rd_entry.packet_total;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         ether_ff     <= '0;
         hw_ff        <= '0;
         pkey_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept && req_opcode == ifbpc_pkg::OP_FRAME) begin
            if (req_last_byte) begin
               ether_ff <= '0;
               hw_ff    <= '0;
               pkey_ff  <= '0;
            end else begin
               ether_ff <= ether_in;
               hw_ff    <= hw_in;
               pkey_ff  <= pkey_in;
            end
         end
      end
      scan_ff   <= scan_in;
      key_ff    <= key_in;
      len_ff    <= len_in;
      status_ff <= status_in;
      index_ff  <= index_in;
      okey_ff   <= okey_in;
      obytes_ff <= obytes_in;
      opkts_ff  <= opkts_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_entry_index  = index_ff;
   assign rsp_src_addr     = okey_ff.src_addr;
   assign rsp_dst_addr     = okey_ff.dst_addr;
   assign rsp_src_port     = okey_ff.sport;
   assign rsp_dst_port     = okey_ff.dport;
   assign rsp_proto        = okey_ff.proto;
   assign rsp_byte_total   = obytes_ff;
   assign rsp_packet_total = opkts_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ifbpc_pkg::CNT_W'(ifbpc_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_scan_in_use: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CMP |-> 32'(scan_ff) < 32'(count_ff))
      else $error("compare on an entry not in use");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |-> count_ff == $past(count_ff) + 1'b1)
      else $error("entry count moved by more than one");

   a_rsp_on_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RDOUT) |=> rsp_valid_ff && status_ff == ifbpc_pkg::ST_READ_VALID)
      else $error("table read gave no result");

endmodule

// File: tb/sv/ipv4_flow_byte_packet_counter_tb.sv
// testbench for the ipv4 flow byte and packet counter: frames and table reads
// are driven through the valid/stall handshake and every result word is
// checked against a behavioral flow table; depends on ifbpc_pkg and the rtl

`timescale 1ns / 100ps

module ipv4_flow_byte_packet_counter_tb;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  entry_index;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] sport;
      logic [15:0] dport;
      logic [7:0]  proto;
      logic [63:0] byte_total;
      logic [63:0] packet_total;
   } flow_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = ifbpc_pkg::OP_FRAME;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic [7:0]  req_read_index = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_entry_index;
   logic [31:0] rsp_src_addr;
   logic [31:0] rsp_dst_addr;
   logic [15:0] rsp_src_port;
   logic [15:0] rsp_dst_port;
   logic [7:0]  rsp_proto;
   logic [63:0] rsp_byte_total;
   logic [63:0] rsp_packet_total;

   ipv4_flow_byte_packet_counter u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_data_byte(req_data_byte), .req_last_byte(req_last_byte),
      .req_read_index(req_read_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_entry_index(rsp_entry_index), .rsp_src_addr(rsp_src_addr),
      .rsp_dst_addr(rsp_dst_addr), .rsp_src_port(rsp_src_port),
      .rsp_dst_port(rsp_dst_port), .rsp_proto(rsp_proto),
      .rsp_byte_total(rsp_byte_total), .rsp_packet_total(rsp_packet_total)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // flow table copy
   ifbpc_pkg::flow_key_type table_keys [ifbpc_pkg::TABLE_DEPTH];
   logic                    table_used [ifbpc_pkg::TABLE_DEPTH];
   logic [63:0]             table_bytes [ifbpc_pkg::TABLE_DEPTH];
   logic [63:0]             table_packets [ifbpc_pkg::TABLE_DEPTH];
   logic [15:0]             frame_pos;
   logic [15:0]             frame_ethertype;
   logic [3:0]              frame_ihl;
   ifbpc_pkg::flow_key_type frame_key;
   flow_result_type         expected_results [$];

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   error_count = 0;
   int   cycle_count = 0;
   int   flows_seen = 0;
   logic [31:0] flow_src [16];

   task automatic clear_frame();
      frame_pos = 16'd0;
      frame_ethertype = 16'd0;
      frame_ihl = 4'd0;
      frame_key = '0;
   endtask

   function automatic flow_result_type make_result(logic [2:0] st, logic [7:0] idx,
         ifbpc_pkg::flow_key_type k, logic [63:0] b, logic [63:0] p);
      flow_result_type r;
      r.status = st;
      r.entry_index = idx;
      r.src_addr = k.src_addr;
      r.dst_addr = k.dst_addr;
      r.sport = k.sport;
      r.dport = k.dport;
      r.proto = k.proto;
      r.byte_total = b;
      r.packet_total = p;
      return r;
   endfunction

   task automatic predict_word(logic op, logic [7:0] data, logic last, logic [7:0] ridx);
      logic [15:0]             pos;
      logic [15:0]             len;
      logic [16:0]             tp;
      ifbpc_pkg::flow_key_type k;
      int                      hit;
      int                      free_slot;
      if (op == ifbpc_pkg::OP_READ) begin
         if (table_used[ridx])
            expected_results.push_back(make_result(ifbpc_pkg::ST_READ_VALID, ridx,
               table_keys[ridx], table_bytes[ridx], table_packets[ridx]));
         else
            expected_results.push_back(make_result(ifbpc_pkg::ST_READ_EMPTY, ridx,
               '0, '0, '0));
         return;
      end
      pos = frame_pos;
      if (pos == 12) frame_ethertype[15:8] = data;
      else if (pos == 13) frame_ethertype[7:0] = data;
      else if (pos == 14) frame_ihl = data[3:0];
      else if (pos == 23) frame_key.proto = data;
      else if (pos >= 26 && pos <= 29) frame_key.src_addr = {frame_key.src_addr[23:0], data};
      else if (pos >= 30 && pos <= 33) frame_key.dst_addr = {frame_key.dst_addr[23:0], data};
      tp = 17'd14 + 17'(frame_ihl) * 4;
      if (pos > 14 && frame_ihl >= ifbpc_pkg::MIN_IHL) begin
         if (pos == tp || pos == tp + 1)
            frame_key.sport = {frame_key.sport[7:0], data};
         else if (pos == tp + 2 || pos == tp + 3)
            frame_key.dport = {frame_key.dport[7:0], data};
      end
      len = (pos != 16'hFFFF) ? pos + 16'd1 : 16'hFFFF;
      if (!last) begin
         frame_pos = len;
         return;
      end
      k = frame_key;
      if (frame_ethertype != ifbpc_pkg::ETHERTYPE_IPV4 || len < ifbpc_pkg::MIN_FRAME_LEN ||
          frame_ihl < ifbpc_pkg::MIN_IHL) begin
         expected_results.push_back(make_result(ifbpc_pkg::ST_NOT_COUNTED, 8'd0,
            '0, '0, '0));
      end else begin
         if (!((k.proto == ifbpc_pkg::PROTO_TCP && 17'(len) >= tp + 20) ||
               (k.proto == ifbpc_pkg::PROTO_UDP && 17'(len) >= tp + 8))) begin
            k.sport = '0;
            k.dport = '0;
         end
         hit = -1;
         free_slot = -1;
         for (int i = 0; i < ifbpc_pkg::TABLE_DEPTH; i++) begin
            if (hit < 0 && table_used[i] && table_keys[i] == k) hit = i;
            if (free_slot < 0 && !table_used[i]) free_slot = i;
         end
         if (hit >= 0) begin
            table_bytes[hit] += 64'(len);
            table_packets[hit] += 64'd1;
            expected_results.push_back(make_result(ifbpc_pkg::ST_HIT, 8'(hit), k,
               table_bytes[hit], table_packets[hit]));
         end else if (free_slot >= 0) begin
            table_used[free_slot] = 1'b1;
            table_keys[free_slot] = k;
            table_bytes[free_slot] = 64'(len);
            table_packets[free_slot] = 64'd1;
            expected_results.push_back(make_result(ifbpc_pkg::ST_NEW, 8'(free_slot), k,
               table_bytes[free_slot], 64'd1));
         end else begin
            expected_results.push_back(make_result(ifbpc_pkg::ST_FULL, 8'd0, k, '0, '0));
         end
      end
      clear_frame();
   endtask

   task automatic send_word(logic op, logic [7:0] data, logic last, logic [7:0] ridx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_opcode <= 1'($urandom);
         req_data_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_data_byte <= data;
      req_last_byte <= last;
      req_read_index <= ridx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_word(op, data, last, ridx);
   endtask

   // one frame; ihl, proto, length and ethertype chosen by caller
   task automatic send_frame(logic [15:0] etype, logic [3:0] ihl, logic [7:0] proto,
         logic [31:0] src, logic [31:0] dst, logic [15:0] sport, logic [15:0] dport,
         int len, bit mix_reads);
      logic [7:0] b;
      int tp;
      tp = 14 + int'(ihl) * 4;
      for (int p = 0; p < len; p++) begin
         b = 8'($urandom);
         if (p == 12) b = etype[15:8];
         else if (p == 13) b = etype[7:0];
         else if (p == 14) b = {4'h4, ihl};
         else if (p == 23) b = proto;
         else if (p >= 26 && p <= 29) b = src[8 * (29 - p) +: 8];
         else if (p >= 30 && p <= 33) b = dst[8 * (33 - p) +: 8];
         else if (ihl >= ifbpc_pkg::MIN_IHL && p == tp) b = sport[15:8];
         else if (ihl >= ifbpc_pkg::MIN_IHL && p == tp + 1) b = sport[7:0];
         else if (ihl >= ifbpc_pkg::MIN_IHL && p == tp + 2) b = dport[15:8];
         else if (ihl >= ifbpc_pkg::MIN_IHL && p == tp + 3) b = dport[7:0];
         if (mix_reads && $urandom_range(29) == 0)
            send_word(ifbpc_pkg::OP_READ, 8'($urandom), 1'($urandom), 8'($urandom));
         send_word(ifbpc_pkg::OP_FRAME, b, p == len - 1, 8'($urandom));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (2 * ifbpc_pkg::TABLE_DEPTH + 20) @(posedge clock);
   endtask

   task automatic random_flow_frame(bit mix_reads);
      logic [7:0] proto;
      logic [3:0] ihl;
      int         sel;
      int         len;
      sel = $urandom_range(9);
      proto = (sel < 4) ? ifbpc_pkg::PROTO_TCP : (sel < 8) ? ifbpc_pkg::PROTO_UDP :
         8'($urandom);
      ihl = ($urandom_range(7) == 0) ? 4'($urandom) : 4'd5 + 4'($urandom_range(2));
      len = $urandom_range(30, 14 + 4 * int'(ihl) + 26);
      send_frame(($urandom_range(15) == 0) ? 16'($urandom) : ifbpc_pkg::ETHERTYPE_IPV4,
         ihl, proto, flow_src[$urandom_range(15)], 32'h0A000001 ^ 32'($urandom_range(3)),
         16'($urandom_range(3)), 16'($urandom), len, mix_reads);
   endtask

   task automatic test_directed();
      // extremes of addresses, ports, protocols
      send_frame(ifbpc_pkg::ETHERTYPE_IPV4, 4'd5, ifbpc_pkg::PROTO_TCP, 32'hFFFFFFFF,
         32'h00000000, 16'hFFFF, 16'h0000, 54, 0);
      send_frame(ifbpc_pkg::ETHERTYPE_IPV4, 4'd5, ifbpc_pkg::PROTO_TCP, 32'hFFFFFFFF,
         32'h00000000, 16'hFFFF, 16'h0000, 54, 0);
      // tcp header cut short: ports dropped
      send_frame(ifbpc_pkg::ETHERTYPE_IPV4, 4'd5, ifbpc_pkg::PROTO_TCP, 32'h00000000,
         32'hFFFFFFFF, 16'h1234, 16'h5678, 53, 0);
      send_frame(ifbpc_pkg::ETHERTYPE_IPV4, 4'd15, ifbpc_pkg::PROTO_UDP, 32'h80000001,
         32'h7FFFFFFE, 16'h0000, 16'hFFFF, 82, 0);
      send_frame(ifbpc_pkg::ETHERTYPE_IPV4, 4'd6, ifbpc_pkg::PROTO_UDP, 32'h01020304,
         32'h05060708, 16'h0035, 16'h0035, 45, 0);
      send_frame(ifbpc_pkg::ETHERTYPE_IPV4, 4'd5, 8'hFF, 32'hC0A80001, 32'hC0A80002,
         16'h1, 16'h2, 34, 0);
      // not counted: wrong ethertype, short frame, small ihl
      send_frame(16'h86DD, 4'd5, ifbpc_pkg::PROTO_TCP, 32'h1, 32'h2, 16'h1, 16'h2, 60, 0);
      send_frame(ifbpc_pkg::ETHERTYPE_IPV4, 4'd5, ifbpc_pkg::PROTO_TCP, 32'h1, 32'h2,
         16'h1, 16'h2, 33, 0);
      send_frame(ifbpc_pkg::ETHERTYPE_IPV4, 4'd4, ifbpc_pkg::PROTO_TCP, 32'h1, 32'h2,
         16'h1, 16'h2, 60, 0);
      send_frame(ifbpc_pkg::ETHERTYPE_IPV4, 4'd0, ifbpc_pkg::PROTO_UDP, 32'h1, 32'h2,
         16'h1, 16'h2, 1, 0);
      // reads: valid, empty, extreme index, inside a frame
      send_word(ifbpc_pkg::OP_READ, 8'hFF, 1'b1, 8'd0);
      send_word(ifbpc_pkg::OP_READ, 8'h00, 1'b0, 8'd255);
      send_word(ifbpc_pkg::OP_READ, 8'h00, 1'b0, 8'd3);
      send_frame(ifbpc_pkg::ETHERTYPE_IPV4, 4'd5, ifbpc_pkg::PROTO_UDP, 32'h0A0B0C0D,
         32'h01010101, 16'h8000, 16'h0001, 60, 1);
      wait_drained();
   endtask

   task automatic test_long_frame();
      // frame longer than 65535 bytes: length saturates
      send_frame(ifbpc_pkg::ETHERTYPE_IPV4, 4'd5, ifbpc_pkg::PROTO_UDP, 32'hDEADBEEF,
         32'h0, 16'h1, 16'h1, 65540, 0);
      send_word(ifbpc_pkg::OP_READ, 8'h0, 1'b0, 8'd0);
      wait_drained();
   endtask

   task automatic test_random(int sidle, int ridle, int words);
      int start;
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      for (int i = 0; i < 16; i++) flow_src[i] = $urandom;
      start = flows_seen;
      while (flows_seen - start < words) begin
         if ($urandom_range(5) == 0) begin
            send_word(ifbpc_pkg::OP_READ, 8'($urandom), 1'($urandom),
               8'($urandom_range(31)));
            flows_seen++;
         end else begin
            random_flow_frame($urandom_range(3) == 0);
            flows_seen += 4;
         end
      end
      wait_drained();
   endtask

   task automatic test_table_full();
      // unique flows until the table overflows, then read every entry
      send_idle_pct = 0;
      recv_idle_pct = 10;
      for (int i = 0; i < ifbpc_pkg::TABLE_DEPTH + 4; i++)
         send_frame(ifbpc_pkg::ETHERTYPE_IPV4, 4'd5, 8'd1, 32'hAC100000 + i, 32'h1,
            16'h0, 16'h0, 34, 0);
      for (int i = 0; i < ifbpc_pkg::TABLE_DEPTH; i++)
         send_word(ifbpc_pkg::OP_READ, 8'($urandom), 1'($urandom), 8'(i));
      random_flow_frame(1);
      wait_drained();
   endtask

   always @(posedge clock) begin
      if (!reset)
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      flow_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result word status %0d", rsp_status);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_entry_index !== want.entry_index) begin
               $error("entry_index expected %0d actual %0d", want.entry_index,
                  rsp_entry_index);
               error_count++;
            end
            if (rsp_src_addr !== want.src_addr) begin
               $error("src_addr expected %h actual %h", want.src_addr, rsp_src_addr);
               error_count++;
            end
            if (rsp_dst_addr !== want.dst_addr) begin
               $error("dst_addr expected %h actual %h", want.dst_addr, rsp_dst_addr);
               error_count++;
            end
            if (rsp_src_port !== want.sport) begin
               $error("rsp_src_port expected %h actual %h", want.sport, rsp_src_port);
               error_count++;
            end
            if (rsp_dst_port !== want.dport) begin
               $error("rsp_dst_port expected %h actual %h", want.dport, rsp_dst_port);
               error_count++;
            end
            if (rsp_proto !== want.proto) begin
               $error("proto expected %0d actual %0d", want.proto, rsp_proto);
               error_count++;
            end
            if (rsp_byte_total !== want.byte_total) begin
               $error("byte_total expected %0d actual %0d", want.byte_total,
                  rsp_byte_total);
               error_count++;
            end
            if (rsp_packet_total !== want.packet_total) begin
               $error("packet_total expected %0d actual %0d", want.packet_total,
                  rsp_packet_total);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < ifbpc_pkg::TABLE_DEPTH; i++) table_used[i] = 1'b0;
      clear_frame();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_long_frame();
      test_random(22, 61, 650);
      test_random(61, 22, 650);
      test_random(0, 0, 650);
      test_table_full();
      if (error_count == 0 && expected_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
rtl/ifbpc_pkg.sv
rtl/ifbpc_ram.sv
rtl/ipv4_flow_byte_packet_counter.sv
tb/sv/ipv4_flow_byte_packet_counter_tb.sv
